/* rtl/buck_boost_integral_current_loop_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the buck-boost integral current loop
// Shared helpers that wrap concurrent assertions on clk with reset disable.
// ----------------------------------------------------------------------------
`ifndef BUCK_BOOST_INTEGRAL_CURRENT_LOOP_MACROS_SVH
`define BUCK_BOOST_INTEGRAL_CURRENT_LOOP_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define BBICL_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define BBICL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define BBICL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/bbicl_pkg.sv */
// ----------------------------------------------------------------------------
// Buck-boost integral current loop package
// Widths, constants, codes, transaction types and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package bbicl_pkg;

  // Converter timing and fixed-point format.
  localparam int PWM_PERIOD = 512;
  localparam int FRAC_BITS  = 8;

  // Field and state widths.
  localparam int SAMPLE_W = 16;
  localparam int DRIVE_W  = 16;
  localparam int GAIN_W   = 4;
  localparam int INTEG_W  = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Arithmetic widths of the integrator update.
  localparam int ERR_W  = SAMPLE_W + 1;
  localparam int PROD_W = ERR_W + GAIN_W + 1;
  localparam int ACC_W  = INTEG_W + 2;
  // Wide enough for max_drive or the period shifted by the fraction bits.
  localparam int WIDE_W = DRIVE_W + 16 + 2;

  localparam logic [INTEG_W-1:0] INTEG_MAX = {INTEG_W{1'b1}};
  localparam logic [DRIVE_W-1:0] DRIVE_MAX = {DRIVE_W{1'b1}};
  localparam logic [DRIVE_W-1:0] PERIOD_VAL = DRIVE_W'(PWM_PERIOD);

  // Integrator preload used on start when vout exceeds vin.
  localparam logic [WIDE_W-1:0] PRELOAD_WIDE = WIDE_W'(PWM_PERIOD) << FRAC_BITS;
  localparam logic [INTEG_W-1:0] PRELOAD =
      (PRELOAD_WIDE > WIDE_W'(INTEG_MAX)) ? INTEG_MAX : PRELOAD_WIDE[INTEG_W-1:0];

  // Register reset values.
  localparam logic [GAIN_W-1:0]   GAIN_RESET      = GAIN_W'(4);
  localparam logic [SAMPLE_W-1:0] VOUT_LIMIT_RESET = SAMPLE_W'(65535);
  localparam logic [DRIVE_W-1:0]  MAX_DRIVE_RESET = DRIVE_W'(1024);

  // Input transaction kinds.
  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_START  = 2'd1,
    KIND_STOP   = 2'd2,
    KIND_TARGET = 2'd3
  } kind_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTEGRAL_GAIN = 2'd0,
    REG_VOUT_LIMIT    = 2'd1,
    REG_MAX_DRIVE     = 2'd2
  } reg_index_t;

  typedef struct packed {
    kind_t                kind;
    logic [SAMPLE_W-1:0]  current_sample;
    logic [SAMPLE_W-1:0]  vout_sample;
    logic [SAMPLE_W-1:0]  vin_level;
    logic [SAMPLE_W-1:0]  vout_level;
    logic [SAMPLE_W-1:0]  target;
  } in_item_t;

  typedef struct packed {
    logic                buck_pwm_on;
    logic                buck_static_level;
    logic [DRIVE_W-1:0]  buck_duty;
    logic                boost_pwm_on;
    logic [DRIVE_W-1:0]  boost_duty;
    logic                converter_off;
    logic                running;
    logic                tripped;
    logic [DRIVE_W-1:0]  drive_value;
  } out_item_t;

  // Integrator shifted down by the fraction bits, saturated to the drive width.
  function automatic logic [DRIVE_W-1:0] drive_of(input logic [INTEG_W-1:0] integ);
    logic [INTEG_W-1:0] shifted;
    shifted = integ >> FRAC_BITS;
    if (shifted > INTEG_W'(DRIVE_MAX)) begin
      return DRIVE_MAX;
    end
    return shifted[DRIVE_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/buck_boost_integral_current_loop.sv */
// ----------------------------------------------------------------------------
// Buck-boost integral current loop
// Integral-only current regulator that turns control ticks into buck and
// boost PWM settings, with start, stop, target load and overvoltage trip.
// An accepted input transaction has its result loaded into the output register.
// Throughput: one transaction per cycle while the output register is empty or
// drained; the single update stage between the loop state and the result
// register sets this figure.
// Reset: synchronous; loop state, configuration registers and out_valid reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "buck_boost_integral_current_loop_macros.svh"

module buck_boost_integral_current_loop (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Configuration write port
  input  wire logic                           cfg_we,
  input  wire logic [bbicl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bbicl_pkg::CFG_DATA_W-1:0] cfg_data,
  // Input channel
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire bbicl_pkg::in_item_t            in_data,
  // Output channel
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output bbicl_pkg::out_item_t                out_data
);

  import bbicl_pkg::*;

  // Configuration registers
  logic [GAIN_W-1:0]   integral_gain;
  logic [SAMPLE_W-1:0] vout_limit;
  logic [DRIVE_W-1:0]  max_drive;

  // Loop state
  logic [INTEG_W-1:0]  integrator;
  logic [SAMPLE_W-1:0] current_target;
  logic                loop_enabled;
  logic                buck_mode_pwm;
  logic                buck_level;
  logic [DRIVE_W-1:0]  buck_compare;
  logic                boost_mode_pwm;
  logic [DRIVE_W-1:0]  boost_compare;
  logic                converter_disabled;

  logic [INTEG_W-1:0]  integrator_next;
  logic [SAMPLE_W-1:0] current_target_next;
  logic                loop_enabled_next;
  logic                buck_mode_pwm_next;
  logic                buck_level_next;
  logic [DRIVE_W-1:0]  buck_compare_next;
  logic                boost_mode_pwm_next;
  logic [DRIVE_W-1:0]  boost_compare_next;
  logic                converter_disabled_next;
  logic                trip;

  logic                in_fire;
  out_item_t           result_next;

  // Integrator update datapath
  logic signed [ERR_W-1:0]  err;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic [WIDE_W-1:0]        cap_wide;
  logic [INTEG_W-1:0]       cap;
  logic [INTEG_W-1:0]       integ_clamped;
  logic [DRIVE_W-1:0]       drive_raw;
  logic [DRIVE_W-1:0]       drive_capped;

  // The output register frees the input side whenever it is empty or drained.
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_gain <= GAIN_RESET;
      vout_limit    <= VOUT_LIMIT_RESET;
      max_drive     <= MAX_DRIVE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INTEGRAL_GAIN: integral_gain <= cfg_data[GAIN_W-1:0];
        REG_VOUT_LIMIT:    vout_limit    <= cfg_data[SAMPLE_W-1:0];
        REG_MAX_DRIVE:     max_drive     <= cfg_data[DRIVE_W-1:0];
        default: ;
      endcase
    end
  end

  // Error times gain added to the integrator, clamped at zero and the cap.
  always_comb begin
    err  = $signed({1'b0, current_target}) - $signed({1'b0, in_data.current_sample});
    prod = PROD_W'(err) * $signed({{(PROD_W-GAIN_W){1'b0}}, integral_gain});
    acc  = $signed({{(ACC_W-INTEG_W){1'b0}}, integrator}) + ACC_W'(prod);

    cap_wide = WIDE_W'(max_drive) << FRAC_BITS;
    cap      = (cap_wide > WIDE_W'(INTEG_MAX)) ? INTEG_MAX : cap_wide[INTEG_W-1:0];

    if (acc[ACC_W-1]) begin
      integ_clamped = '0;
    end else if (acc[ACC_W-2:0] > (ACC_W-1)'(cap)) begin
      integ_clamped = cap;
    end else begin
      integ_clamped = acc[INTEG_W-1:0];
    end

    drive_raw    = drive_of(integ_clamped);
    drive_capped = (drive_raw > max_drive) ? max_drive : drive_raw;
  end

  // Next loop state for the accepted transaction.
  always_comb begin
    integrator_next         = integrator;
    current_target_next     = current_target;
    loop_enabled_next       = loop_enabled;
    buck_mode_pwm_next      = buck_mode_pwm;
    buck_level_next         = buck_level;
    buck_compare_next       = buck_compare;
    boost_mode_pwm_next     = boost_mode_pwm;
    boost_compare_next      = boost_compare;
    converter_disabled_next = converter_disabled;
    trip                    = 1'b0;

    unique case (in_data.kind)
      KIND_TICK: begin
        if (loop_enabled) begin
          if (in_data.vout_sample >= vout_limit) begin
            // Overvoltage: shut the converter down, keep the compares.
            trip                    = 1'b1;
            loop_enabled_next       = 1'b0;
            buck_mode_pwm_next      = 1'b0;
            buck_level_next         = 1'b0;
            boost_mode_pwm_next     = 1'b0;
            converter_disabled_next = 1'b1;
          end else begin
            integrator_next = integ_clamped;
            if (drive_capped <= PERIOD_VAL) begin
              boost_mode_pwm_next = 1'b0;
              buck_mode_pwm_next  = 1'b1;
              buck_compare_next   = drive_capped;
            end else begin
              buck_mode_pwm_next  = 1'b0;
              buck_level_next     = 1'b1;
              boost_mode_pwm_next = 1'b1;
              boost_compare_next  = drive_capped - PERIOD_VAL;
            end
          end
        end
      end
      KIND_START: begin
        buck_mode_pwm_next      = 1'b0;
        buck_level_next         = 1'b0;
        boost_mode_pwm_next     = 1'b0;
        converter_disabled_next = 1'b0;
        current_target_next     = '0;
        integrator_next         = (in_data.vout_level > in_data.vin_level) ? PRELOAD : '0;
        loop_enabled_next       = 1'b1;
      end
      KIND_STOP: begin
        loop_enabled_next       = 1'b0;
        buck_mode_pwm_next      = 1'b0;
        buck_level_next         = 1'b0;
        boost_mode_pwm_next     = 1'b0;
        converter_disabled_next = 1'b1;
      end
      KIND_TARGET: begin
        current_target_next = in_data.target;
      end
      default: ;
    endcase

    result_next.buck_pwm_on       = buck_mode_pwm_next;
    result_next.buck_static_level = buck_level_next;
    result_next.buck_duty         = buck_compare_next;
    result_next.boost_pwm_on      = boost_mode_pwm_next;
    result_next.boost_duty        = boost_compare_next;
    result_next.converter_off     = converter_disabled_next;
    result_next.running           = loop_enabled_next;
    result_next.tripped           = trip;
    result_next.drive_value       = drive_of(integrator_next);
  end

  // Loop state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      integrator         <= '0;
      current_target     <= '0;
      loop_enabled       <= 1'b0;
      buck_mode_pwm      <= 1'b0;
      buck_level         <= 1'b0;
      buck_compare       <= '0;
      boost_mode_pwm     <= 1'b0;
      boost_compare      <= '0;
      converter_disabled <= 1'b1;
    end else if (in_fire) begin
      integrator         <= integrator_next;
      current_target     <= current_target_next;
      loop_enabled       <= loop_enabled_next;
      buck_mode_pwm      <= buck_mode_pwm_next;
      buck_level         <= buck_level_next;
      buck_compare       <= buck_compare_next;
      boost_mode_pwm     <= boost_mode_pwm_next;
      boost_compare      <= boost_compare_next;
      converter_disabled <= converter_disabled_next;
    end
  end

  // Result register: valid flag under reset, payload loaded on each transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= result_next;
    end
  end

  // Design checks.
  `BBICL_ASSERT_ALWAYS(a_legs_exclusive, !(buck_mode_pwm && boost_mode_pwm), "both legs in PWM")
  `BBICL_ASSERT_SAME(a_boost_needs_buck_high, boost_mode_pwm, buck_level, "boost PWM without buck high")
  `BBICL_ASSERT_SAME(a_trip_shuts_down, out_valid && out_data.tripped,
                     !out_data.running && out_data.converter_off, "trip left the loop running")
  `BBICL_ASSERT_SAME(a_run_enables_converter, out_valid && out_data.running,
                     !out_data.converter_off, "loop running with converter off")
  `BBICL_ASSERT_NEXT(a_idle_tick_holds, in_fire && in_data.kind == KIND_TICK && !loop_enabled,
                     $stable(integrator) && !out_data.tripped, "idle tick changed the loop")

endmodule

`default_nettype wire

/* sim/loop_response_monitor.sv */
// ----------------------------------------------------------------------------
// Response monitor for the buck-boost integral current loop
// Follows register writes and input transactions, predicts the result of
// each one from its own copy of the loop state, and compares every result
// transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module loop_response_monitor (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bbicl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbicl_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  bbicl_pkg::in_item_t              in_data,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  bbicl_pkg::out_item_t             out_data,
  output int                               fail_count,
  output int                               pending
);

  import bbicl_pkg::*;

  // Register copies.
  logic [GAIN_W-1:0]   gain_r;
  logic [SAMPLE_W-1:0] limit_r;
  logic [DRIVE_W-1:0]  max_drive_r;

  // Loop state copies.
  logic [INTEG_W-1:0]  integ;
  logic [SAMPLE_W-1:0] target_r;
  logic                loop_on;
  logic                buck_pwm;
  logic                buck_high;
  logic [DRIVE_W-1:0]  buck_cmp;
  logic                boost_pwm;
  logic [DRIVE_W-1:0]  boost_cmp;
  logic                conv_off;

  out_item_t expected_results[$];
  out_item_t oldest;

  initial fail_count = 0;

  // Integrator with the fraction bits dropped, saturated to the drive width.
  function automatic logic [DRIVE_W-1:0] drive_level(logic [INTEG_W-1:0] x);
    logic [INTEG_W-1:0] whole;
    whole = x >> FRAC_BITS;
    return (whole > INTEG_W'(DRIVE_MAX)) ? DRIVE_MAX : whole[DRIVE_W-1:0];
  endfunction

  function automatic void legs_low();
    buck_pwm  = 1'b0;
    buck_high = 1'b0;
    boost_pwm = 1'b0;
  endfunction

  function automatic void shut_off();
    loop_on  = 1'b0;
    conv_off = 1'b1;
    legs_low();
  endfunction

  // Advances the loop state by one transaction and returns its result.
  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    longint sum;
    longint ceiling;
    longint preload;
    logic [DRIVE_W-1:0] v;
    logic trip_now;
    trip_now = 1'b0;
    case (it.kind)
      KIND_TICK: begin
        if (loop_on) begin
          if (it.vout_sample >= limit_r) begin
            shut_off();
            trip_now = 1'b1;
          end else begin
            sum = longint'(integ) +
                  (longint'(target_r) - longint'(it.current_sample)) * longint'(gain_r);
            ceiling = longint'(max_drive_r) << FRAC_BITS;
            if (ceiling > longint'(INTEG_MAX)) ceiling = longint'(INTEG_MAX);
            if (sum < 0) sum = 0;
            if (sum > ceiling) sum = ceiling;
            integ = sum[INTEG_W-1:0];
            v = drive_level(integ);
            if (v > max_drive_r) v = max_drive_r;
            // Buck region up to the period, boost region above it.
            if (v <= PERIOD_VAL) begin
              boost_pwm = 1'b0;
              buck_pwm  = 1'b1;
              buck_cmp  = v;
            end else begin
              buck_pwm  = 1'b0;
              buck_high = 1'b1;
              boost_pwm = 1'b1;
              boost_cmp = v - PERIOD_VAL;
            end
          end
        end
      end
      KIND_START: begin
        legs_low();
        conv_off = 1'b0;
        target_r = '0;
        preload  = 0;
        if (it.vout_level > it.vin_level) preload = longint'(PWM_PERIOD) << FRAC_BITS;
        if (preload > longint'(INTEG_MAX)) preload = longint'(INTEG_MAX);
        integ   = preload[INTEG_W-1:0];
        loop_on = 1'b1;
      end
      KIND_STOP: shut_off();
      default: target_r = it.target;
    endcase
    r.buck_pwm_on       = buck_pwm;
    r.buck_static_level = buck_high;
    r.buck_duty         = buck_cmp;
    r.boost_pwm_on      = boost_pwm;
    r.boost_duty        = boost_cmp;
    r.converter_off     = conv_off;
    r.running           = loop_on;
    r.tripped           = trip_now;
    r.drive_value       = drive_level(integ);
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Inputs are driven on the rising edge with nonblocking assignments, so the
  // values read here are the ones the block saw at this edge.
  always @(posedge clk) begin
    if (rst) begin
      gain_r      = GAIN_RESET;
      limit_r     = VOUT_LIMIT_RESET;
      max_drive_r = MAX_DRIVE_RESET;
      integ       = '0;
      target_r    = '0;
      loop_on     = 1'b0;
      buck_pwm    = 1'b0;
      buck_high   = 1'b0;
      buck_cmp    = '0;
      boost_pwm   = 1'b0;
      boost_cmp   = '0;
      conv_off    = 1'b1;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_INTEGRAL_GAIN: gain_r      = cfg_data[GAIN_W-1:0];
          REG_VOUT_LIMIT:    limit_r     = cfg_data;
          REG_MAX_DRIVE:     max_drive_r = cfg_data;
          default: ;
        endcase
      end
      // A result transaction is matched against the oldest prediction.
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no prediction waiting");
          fail_count++;
        end else begin
          oldest = expected_results.pop_front();
          check_field("buck_pwm_on", oldest.buck_pwm_on, out_data.buck_pwm_on);
          check_field("buck_static_level", oldest.buck_static_level,
                      out_data.buck_static_level);
          check_field("buck_duty", oldest.buck_duty, out_data.buck_duty);
          check_field("boost_pwm_on", oldest.boost_pwm_on, out_data.boost_pwm_on);
          check_field("boost_duty", oldest.boost_duty, out_data.boost_duty);
          check_field("converter_off", oldest.converter_off, out_data.converter_off);
          check_field("running", oldest.running, out_data.running);
          check_field("tripped", oldest.tripped, out_data.tripped);
          check_field("drive_value", oldest.drive_value, out_data.drive_value);
        end
      end
      if (in_valid && in_ready) expected_results.push_back(predict_result(in_data));
    end
    pending <= expected_results.size();
  end

endmodule

/* sim/tb_buck_boost_integral_current_loop.sv */
// ----------------------------------------------------------------------------
// Testbench for the buck-boost integral current loop
// Drives directed and random start, stop, target and tick transactions
// through several register settings, with random idling on both channels,
// and takes its verdict from the response monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_buck_boost_integral_current_loop;
  import bbicl_pkg::*;

  localparam int NUM_PHASES     = 7;
  localparam int PHASE_ITEMS    = 82;
  localparam int LONG_HOLD      = 150;
  localparam int WATCHDOG_LIMIT = 3000;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;

  int fail_count;
  int pending;
  int stall_cycles = 0;

  // Stimulus controls shared between the sender and the receiver.
  bit quiet         = 1'b0;
  bit burst         = 1'b0;
  bit long_hold_req = 1'b0;
  logic [SAMPLE_W-1:0] tb_target = '0;
  logic [SAMPLE_W-1:0] tb_limit  = VOUT_LIMIT_RESET;

  // Register settings per phase; the first one repeats the reset values.
  int phase_gain[NUM_PHASES]  = '{4, 15, 0, 1, 15, 7, 9};
  int phase_limit[NUM_PHASES] = '{65535, 65535, 40000, 0, 30000, 60000, 65535};
  int phase_drive[NUM_PHASES] = '{1024, 65535, 300, 700, 0, 512, 513};

  buck_boost_integral_current_loop i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  loop_response_monitor i_monitor (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Idle lengths: mostly none or short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] rand16();
    return 16'($urandom);
  endfunction

  function automatic in_item_t item_of(kind_t k, logic [15:0] cur, logic [15:0] vs,
                                       logic [15:0] vin, logic [15:0] vout,
                                       logic [15:0] tgt);
    in_item_t it;
    it.kind           = k;
    it.current_sample = cur;
    it.vout_sample    = vs;
    it.vin_level      = vin;
    it.vout_level     = vout;
    it.target         = tgt;
    return it;
  endfunction

  // Mostly ticks around the target, with target loads, restarts and stops.
  function automatic in_item_t random_item();
    int r;
    int c;
    in_item_t it;
    r  = $urandom_range(0, 99);
    it = item_of(KIND_TICK, rand16(), rand16(), rand16(), rand16(), rand16());
    if (r < 6) begin
      it.kind = KIND_START;
      if ($urandom_range(0, 1)) begin
        it.vout_level = SAMPLE_W'($urandom_range(it.vin_level, 65535));
      end
      tb_target = '0;
    end else if (r < 10) begin
      it.kind = KIND_STOP;
    end else if (r < 24) begin
      it.kind = KIND_TARGET;
      if ($urandom_range(0, 1)) it.target = SAMPLE_W'($urandom_range(0, 1500));
      tb_target = it.target;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        c = int'(tb_target) + int'($urandom_range(0, 400)) - 200;
        it.current_sample = (c < 0) ? 16'd0 : (c > 65535) ? 16'hFFFF : 16'(c);
      end else if (r >= 85) begin
        it.current_sample = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end
      if (tb_limit != 0) begin
        if ($urandom_range(0, 99) < 92) begin
          it.vout_sample = SAMPLE_W'($urandom_range(0, tb_limit - 1));
        end else begin
          it.vout_sample = SAMPLE_W'($urandom_range(tb_limit, 65535));
        end
      end
    end
    return it;
  endfunction

  // Offers one transaction and returns once it is accepted, after any random idle gap.
  task automatic send_item(in_item_t it);
    int gap;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering and waits until every predicted result has arrived.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Writes all three registers back to back; only called while idle.
  task automatic set_regs(int gain, int limit, int max_drive);
    cfg_we    <= 1'b1;
    cfg_index <= REG_INTEGRAL_GAIN;
    cfg_data  <= CFG_DATA_W'(gain);
    @(posedge clk);
    cfg_index <= REG_VOUT_LIMIT;
    cfg_data  <= CFG_DATA_W'(limit);
    @(posedge clk);
    cfg_index <= REG_MAX_DRIVE;
    cfg_data  <= CFG_DATA_W'(max_drive);
    @(posedge clk);
    cfg_we   <= 1'b0;
    tb_limit = SAMPLE_W'(limit);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int hold;
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: disabled tick, both preloads, clamps, trip boundary.
    set_regs(4, 50000, 1024);
    send_item(item_of(KIND_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(item_of(KIND_TARGET, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
    send_item(item_of(KIND_START, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000));
    send_item(item_of(KIND_TARGET, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
    send_item(item_of(KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_item(item_of(KIND_TICK, 16'hFFFF, 16'd49999, 16'h0000, 16'h0000, 16'h0000));
    send_item(item_of(KIND_TARGET, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000));
    send_item(item_of(KIND_TICK, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_item(item_of(KIND_TICK, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_item(item_of(KIND_TICK, 16'h0000, 16'd50000, 16'h0000, 16'h0000, 16'h0000));
    send_item(item_of(KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_item(item_of(KIND_START, 16'h0000, 16'h0000, 16'd1000, 16'd1000, 16'h0000));
    send_item(item_of(KIND_TARGET, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd600));
    send_item(item_of(KIND_TICK, 16'h0000, 16'd100, 16'h0000, 16'h0000, 16'h0000));
    send_item(item_of(KIND_TICK, 16'd400, 16'd100, 16'h0000, 16'h0000, 16'h0000));
    send_item(item_of(KIND_STOP, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_item(item_of(KIND_START, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF));
    send_item(item_of(KIND_STOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(item_of(KIND_START, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));

    // Random part, one register setting per phase.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      set_regs(phase_gain[p], phase_limit[p], phase_drive[p]);
      quiet = (p == 5);
      tb_target = '0;
      send_item(item_of(KIND_START, rand16(), rand16(), 16'd100,
                        $urandom_range(0, 1) ? 16'd200 : 16'd50, rand16()));
      if (p == 2) begin
        // Receiver holds off while the sender keeps offering back to back.
        long_hold_req = 1'b1;
        burst = 1'b1;
        repeat (40) send_item(random_item());
        burst = 1'b0;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 4 && n == PHASE_ITEMS / 2) wait_drained();
        send_item(random_item());
      end
    end

    wait_drained();
    repeat (5) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/bbicl_pkg.sv
rtl/buck_boost_integral_current_loop.sv
sim/loop_response_monitor.sv
sim/tb_buck_boost_integral_current_loop.sv
